// ----- design/sum_checked_packet_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sum checked packet deframer
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_PACKET_DEFRAMER_MACROS_SVH
`define SUM_CHECKED_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SCPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/scpd_pkg.sv -----
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types and constants of the sum checked packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int IDX_W           = 5;
  localparam int CFG_IDX_W       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_LIMIT   = 2'd2;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd175;
  localparam logic [LEN_W-1:0]  LEN_LIMIT_RST   = 6'd32;

  // request kinds on the input channel
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5
  } phase_t;

  typedef enum logic {
    B_IDLE  = 1'b0,
    B_FETCH = 1'b1
  } bstate_t;

  // descriptor of a frame that passed its checksum
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

endpackage

`default_nettype wire

// ----- design/scpd_ifs.sv -----
// ----------------------------------------------------------------------------
// scpd channel interfaces
// Valid/ready channels for incoming link requests and outgoing results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scpd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [scpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface scpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [scpd_pkg::BYTE_W-1:0] message_id;
  logic [scpd_pkg::LEN_W-1:0]  payload_length;
  logic [scpd_pkg::IDX_W-1:0]  byte_index;
  logic [scpd_pkg::BYTE_W-1:0] payload_byte;
  logic                        has_payload;
  logic                        last;

  modport source (output valid, output message_id, output payload_length,
                  output byte_index, output payload_byte, output has_payload,
                  output last, input ready);
  modport sink   (input valid, input message_id, input payload_length,
                  input byte_index, input payload_byte, input has_payload,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- design/scpd_ram.sv -----
// ----------------------------------------------------------------------------
// scpd_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpd_ram #(
  parameter int WIDTH = scpd_pkg::BYTE_W,
  parameter int DEPTH = 2 * scpd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/scpd_fifo.sv -----
// ----------------------------------------------------------------------------
// scpd_fifo
// Two entry descriptor queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire scpd_pkg::desc_t push_desc,
  input  wire logic            pop,
  output scpd_pkg::desc_t      head,
  output logic                 full,
  output logic                 empty
);

  scpd_pkg::desc_t q_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- design/scpd_front.sv -----
// ----------------------------------------------------------------------------
// scpd_front
// Frame parser: sync hunt, header, payload capture and checksum check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpd_front #(
  parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW         = $clog2(2 * MAX_PAYLOAD)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  scpd_in_if.sink                             in_ch,
  input  wire logic                           cfg_we,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scpd_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           q_full,
  output logic                                push,
  output scpd_pkg::desc_t                     push_desc,
  output logic                                ram_we,
  output logic      [AW-1:0]                  ram_waddr,
  output logic      [scpd_pkg::BYTE_W-1:0]    ram_wdata
);

  localparam logic [scpd_pkg::LEN_W-1:0] MAX_LEN = scpd_pkg::LEN_W'(MAX_PAYLOAD);

  logic [scpd_pkg::BYTE_W-1:0] first_r, second_r;
  logic [scpd_pkg::LEN_W-1:0]  limit_r;

  scpd_pkg::phase_t            phase_r, phase_nxt;
  logic [scpd_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [scpd_pkg::BYTE_W-1:0] id_r, id_nxt;
  logic [scpd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [scpd_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic                        wb_r, wb_nxt;

  logic                        accept;
  logic [scpd_pkg::LEN_W-1:0]  lim;
  logic [scpd_pkg::LEN_W-1:0]  cnt_inc;
  logic [scpd_pkg::BYTE_W-1:0] c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= scpd_pkg::FIRST_SYNC_RST;
      second_r <= scpd_pkg::SECOND_SYNC_RST;
      limit_r  <= scpd_pkg::LEN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scpd_pkg::REG_FIRST_SYNC:  first_r  <= cfg_wdata;
        scpd_pkg::REG_SECOND_SYNC: second_r <= cfg_wdata;
        scpd_pkg::REG_LEN_LIMIT:   limit_r  <= cfg_wdata[scpd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // the bank being filled is still owned by a queued frame only when the queue is full
  assign in_ch.ready = !(q_full && (phase_r == scpd_pkg::PH_DATA ||
                                    phase_r == scpd_pkg::PH_SUM));
  assign accept  = in_ch.valid && in_ch.ready;
  assign c       = in_ch.rx_byte;
  assign lim     = (limit_r > MAX_LEN) ? MAX_LEN : limit_r;
  assign cnt_inc = cnt_r + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scpd_pkg::PH_SYNC1;
      sum_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      wb_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      wb_r    <= wb_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    wb_nxt    = wb_r;
    ram_we    = 1'b0;
    ram_waddr = wb_r ? AW'(MAX_PAYLOAD) + AW'(cnt_r) : AW'(cnt_r);
    ram_wdata = c;
    push      = 1'b0;
    push_desc = '{id: id_r, len: len_r, bank: wb_r};
    if (accept) begin
      if (in_ch.kind == scpd_pkg::KIND_TIMEOUT) begin
        phase_nxt = scpd_pkg::PH_SYNC1;
      end else begin
        unique case (phase_r)
          scpd_pkg::PH_SYNC2: begin
            phase_nxt = (c == second_r) ? scpd_pkg::PH_ID : scpd_pkg::PH_SYNC1;
            sum_nxt   = sum_r + c;
          end
          scpd_pkg::PH_ID: begin
            id_nxt    = c;
            phase_nxt = scpd_pkg::PH_LEN;
            sum_nxt   = sum_r + c;
          end
          scpd_pkg::PH_LEN: begin
            if (c <= {2'b00, lim}) begin
              len_nxt   = c[scpd_pkg::LEN_W-1:0];
              cnt_nxt   = '0;
              phase_nxt = (c != 8'd0) ? scpd_pkg::PH_DATA : scpd_pkg::PH_SUM;
              sum_nxt   = sum_r + c;
            end else begin
              phase_nxt = scpd_pkg::PH_SYNC1;
            end
          end
          scpd_pkg::PH_DATA: begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_inc;
            sum_nxt = sum_r + c;
            if (cnt_inc >= len_r) phase_nxt = scpd_pkg::PH_SUM;
          end
          scpd_pkg::PH_SUM: begin
            if (sum_r == c) begin
              push   = 1'b1;
              wb_nxt = ~wb_r;
            end
            phase_nxt = scpd_pkg::PH_SYNC1;
          end
          default: begin
            phase_nxt = (c == first_r) ? scpd_pkg::PH_SYNC2 : scpd_pkg::PH_SYNC1;
            sum_nxt   = c;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/scpd_back.sv -----
// ----------------------------------------------------------------------------
// scpd_back
// Frame emitter: sends an empty frame marker or reads a stored payload and sends one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpd_back #(
  parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW         = $clog2(2 * MAX_PAYLOAD)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  scpd_out_if.source                       out_ch,
  input  wire scpd_pkg::desc_t             head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             ram_re,
  output logic      [AW-1:0]               ram_raddr,
  input  wire logic [scpd_pkg::BYTE_W-1:0] ram_rdata
);

  scpd_pkg::bstate_t           state_r, state_nxt;
  logic [scpd_pkg::LEN_W-1:0]  k_r, k_nxt;
  logic [scpd_pkg::LEN_W-1:0]  k_inc;
  logic                        out_free;
  logic                        load;
  logic                        valid_r;

  logic [scpd_pkg::BYTE_W-1:0] id_r, id_nxt;
  logic [scpd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [scpd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [scpd_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic                        has_r, has_nxt;
  logic                        last_r, last_nxt;

  assign out_free = !valid_r || out_ch.ready;
  assign k_inc    = k_r + 6'd1;

  assign out_ch.valid          = valid_r;
  assign out_ch.message_id     = id_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.byte_index     = idx_r;
  assign out_ch.payload_byte   = data_r;
  assign out_ch.has_payload    = has_r;
  assign out_ch.last           = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scpd_pkg::B_IDLE;
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (load)              valid_r <= 1'b1;
      else if (out_ch.ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      idx_r  <= idx_nxt;
      data_r <= data_nxt;
      has_r  <= has_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pop       = 1'b0;
    load      = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head.bank ? AW'(MAX_PAYLOAD) + AW'(k_r) : AW'(k_r);
    id_nxt    = head.id;
    len_nxt   = head.len;
    idx_nxt   = k_r[scpd_pkg::IDX_W-1:0];
    data_nxt  = ram_rdata;
    has_nxt   = 1'b1;
    last_nxt  = (k_inc == head.len);
    unique case (state_r)
      scpd_pkg::B_IDLE: begin
        if (!empty) begin
          if (head.len == '0) begin
            // empty frame: a single marker result, no payload read
            if (out_free) begin
              load     = 1'b1;
              pop      = 1'b1;
              idx_nxt  = '0;
              data_nxt = '0;
              has_nxt  = 1'b0;
              last_nxt = 1'b1;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head.bank ? AW'(MAX_PAYLOAD) : '0;
            k_nxt     = '0;
            state_nxt = scpd_pkg::B_FETCH;
          end
        end
      end
      scpd_pkg::B_FETCH: begin
        // read data for byte k_r sits on the RAM output until the next read
        if (out_free) begin
          load = 1'b1;
          if (last_nxt) begin
            pop       = 1'b1;
            state_nxt = scpd_pkg::B_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head.bank ? AW'(MAX_PAYLOAD) + AW'(k_inc) : AW'(k_inc);
            k_nxt     = k_inc;
          end
        end
      end
      default: state_nxt = scpd_pkg::B_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/sum_checked_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// sum_checked_packet_deframer
// Sync-header, length-framed packet parser with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// The parser takes one link byte or timeout tick per cycle. A frame whose
// checksum matches is queued and then sent as one result per payload byte
// (one result marked empty for a zero length frame): with the emitter idle,
// the first result passes the descriptor queue, the registered RAM read and
// the output register (an empty frame skips the RAM read); the rest follow
// one per cycle while the receiver is ready. The RAM holds 2 x MAX_PAYLOAD
// bytes as two banks, so the next frame is captured while the last one is
// sent; the input stalls in the payload or checksum phase only while two good
// frames are still waiting to be sent. The RAM needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_packet_deframer #(
  parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  scpd_in_if.sink                             in_ch,
  scpd_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scpd_pkg::BYTE_W-1:0]    cfg_wdata
);

  localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
  localparam int AW        = $clog2(RAM_DEPTH);

  scpd_pkg::desc_t             push_desc, head;
  logic                        push, pop, q_full, q_empty;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [scpd_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  scpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  scpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  scpd_ram #(.WIDTH(scpd_pkg::BYTE_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_ch    (out_ch),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- design/scpd_checker.sv -----
// ----------------------------------------------------------------------------
// scpd_checker
// Port-level checks on the result stream of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_packet_deframer_macros.svh"

module scpd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [scpd_pkg::LEN_W-1:0]  payload_length,
  input wire logic [scpd_pkg::IDX_W-1:0]  byte_index,
  input wire logic                        has_payload,
  input wire logic                        last
);

  logic out_take;
  assign out_take = out_valid && out_ready;

  `SCPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SCPD_ASSERT_IMP(a_empty_shape, out_valid && !has_payload, last && byte_index == '0 && payload_length == '0, "bad empty frame result")
  `SCPD_ASSERT_IMP(a_index_range, out_valid && has_payload, {1'b0, byte_index} < payload_length, "byte index past frame length")
  `SCPD_ASSERT_NEXT(a_frame_gapless, out_take && !last, out_valid, "gap inside a frame")

endmodule

bind sum_checked_packet_deframer scpd_checker u_scpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_length (out_ch.payload_length),
  .byte_index     (out_ch.byte_index),
  .has_payload    (out_ch.has_payload),
  .last           (out_ch.last)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: sum checked packet deframer testbench
// Drives link bytes and timeout ticks into the deframer and predicts, byte by
// byte, which frames pass their sum check. Each result is matched against the
// oldest predicted one. Covers register settings, random framing with noise
// and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import scpd_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;

  scpd_in_if  in_ch ();
  scpd_out_if out_ch ();

  sum_checked_packet_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies
  logic [BYTE_W-1:0] fs_reg;
  logic [BYTE_W-1:0] ss_reg;
  logic [LEN_W-1:0]  lim_reg;

  // parser copy
  phase_t            frame_phase;
  logic [BYTE_W-1:0] sum_acc;
  logic [BYTE_W-1:0] held_id_m;
  logic [LEN_W-1:0]  held_len_m;
  logic [LEN_W-1:0]  byte_cnt_m;
  logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD_DEF];

  result_t pending_results [$];

  int n_requests;
  int n_frames;
  int n_results;
  int n_errors;
  int idle_cycles;
  bit in_calm;
  bit out_calm;
  int stall_token;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- prediction ----------------
  function automatic int limit_now();
    return (int'(lim_reg) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(lim_reg);
  endfunction

  task automatic parse_link_byte(input logic k, input logic [BYTE_W-1:0] c);
    result_t r;
    int      n;
    if (k == KIND_TIMEOUT) begin
      frame_phase = PH_SYNC1;
      return;
    end
    case (frame_phase)
      PH_SYNC2: begin
        frame_phase = (c == ss_reg) ? PH_ID : PH_SYNC1;
        sum_acc = sum_acc + c;
      end
      PH_ID: begin
        held_id_m = c;
        frame_phase = PH_LEN;
        sum_acc = sum_acc + c;
      end
      PH_LEN: begin
        if (int'(c) <= limit_now()) begin
          held_len_m = c[LEN_W-1:0];
          byte_cnt_m = '0;
          frame_phase = (c > 0) ? PH_DATA : PH_SUM;
          sum_acc = sum_acc + c;
        end else begin
          frame_phase = PH_SYNC1;
        end
      end
      PH_DATA: begin
        if (int'(byte_cnt_m) < MAX_PAYLOAD_DEF) payload_copy[byte_cnt_m] = c;
        byte_cnt_m = byte_cnt_m + 1'b1;
        sum_acc = sum_acc + c;
        if (byte_cnt_m >= held_len_m) frame_phase = PH_SUM;
      end
      PH_SUM: begin
        if (sum_acc == c) begin
          n = int'(held_len_m);
          if (n == 0) begin
            r = '{held_id_m, '0, '0, '0, 1'b0, 1'b1};
            pending_results.push_back(r);
          end
          for (int i = 0; i < n; i++) begin
            r.id   = held_id_m;
            r.len  = held_len_m;
            r.idx  = i[IDX_W-1:0];
            r.data = payload_copy[i];
            r.has  = 1'b1;
            r.last = (i == n - 1);
            pending_results.push_back(r);
          end
        end
        frame_phase = PH_SYNC1;
      end
      default: begin
        frame_phase = (c == fs_reg) ? PH_SYNC2 : PH_SYNC1;
        sum_acc = c;
      end
    endcase
  endtask

  // ---------------- result side ----------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      n_errors++;
      $display("%0t: result with none expected, expected nothing, got id %0d index %0d",
               $time, out_ch.message_id, out_ch.byte_index);
      return;
    end
    want = pending_results.pop_front();
    n_results++;
    compare_field("message_id", want.id, out_ch.message_id);
    compare_field("payload_length", want.len, out_ch.payload_length);
    compare_field("byte_index", want.idx, out_ch.byte_index);
    compare_field("payload_byte", want.data, out_ch.payload_byte);
    compare_field("has_payload", want.has, out_ch.has_payload);
    compare_field("last", want.last, out_ch.last);
  endtask

  // receiver: checks, random ready, long hold-off on request
  initial begin
    int hold_left;
    int stall_seen;
    hold_left = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) check_result();
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= out_calm ? 1'b1 : ($urandom_range(99) >= 28);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("sum_checked_packet_deframer test failed");
    $finish;
  end

  // ---------------- stimulus helpers ----------------
  // valid is left high after acceptance; the next call lowers or reuses it
  task automatic send_request(input logic k, input logic [BYTE_W-1:0] b);
    while (!in_calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_requests++;
    parse_link_byte(k, b);
  endtask

  // cut < 0 sends the whole frame, else cut bytes (at most the whole frame) and then a timeout tick
  task automatic send_frame(input logic [BYTE_W-1:0] id, input int len,
                            input bit extreme, input bit bad_sum, input int cut);
    logic [BYTE_W-1:0] bytes [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int n;
    bytes = '{fs_reg, ss_reg, id, len[BYTE_W-1:0]};
    sum = fs_reg + ss_reg + id + len[BYTE_W-1:0];
    for (int k = 0; k < len; k++) begin
      b = extreme ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      bytes.push_back(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    n = (cut < 0 || cut > bytes.size()) ? bytes.size() : cut;
    n_frames++;
    for (int k = 0; k < n; k++) send_request(KIND_BYTE, bytes[k]);
    if (cut >= 0) send_request(KIND_TIMEOUT, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [BYTE_W-1:0] fs, input logic [BYTE_W-1:0] ss,
                              input logic [BYTE_W-1:0] lim);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [BYTE_W-1:0]    val [3];
    idx = '{REG_FIRST_SYNC, REG_SECOND_SYNC, REG_LEN_LIMIT};
    val = '{fs, ss, lim};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    fs_reg  = fs;
    ss_reg  = ss;
    lim_reg = lim[LEN_W-1:0];
  endtask

  function automatic int pick_len(input int lim);
    int r;
    r = $urandom_range(99);
    if (lim == 0) return 0;
    if (r < 10) return lim;
    if (r < 70) return $urandom_range(0, (lim < 6) ? lim : 6);
    return $urandom_range(0, lim);
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed_frames();
    send_frame(8'h00, 0, 1'b0, 1'b0, -1);
    send_frame(8'hFF, 1, 1'b1, 1'b0, -1);
    send_frame(8'h3C, 0, 1'b0, 1'b1, -1);
    // second sync missed: the byte is not taken as a new first sync
    send_request(KIND_BYTE, fs_reg);
    send_request(KIND_BYTE, fs_reg);
    send_request(KIND_BYTE, ss_reg);
    // length over the limit
    send_request(KIND_BYTE, fs_reg);
    send_request(KIND_BYTE, ss_reg);
    send_request(KIND_BYTE, 8'h11);
    send_request(KIND_BYTE, 8'd33);
    // timeout inside the payload
    send_frame(8'h22, 2, 1'b0, 1'b0, 5);
    drain();
  endtask

  task automatic test_register_settings();
    program_regs(8'h00, 8'hFF, 8'd0);
    send_frame(8'h81, 0, 1'b0, 1'b0, -1);
    send_frame(8'h82, 1, 1'b0, 1'b0, -1);
    send_frame(8'h83, 0, 1'b0, 1'b0, -1);
    drain();
    // 63 saturates to the payload size
    program_regs(8'hFF, 8'h00, 8'hFF);
    send_frame(8'hA5, MAX_PAYLOAD_DEF, 1'b1, 1'b0, -1);
    send_frame(8'h5A, MAX_PAYLOAD_DEF + 1, 1'b0, 1'b0, -1);
    send_frame(8'h01, 3, 1'b0, 1'b0, -1);
    drain();
    // equal sync bytes
    program_regs(8'h5A, 8'h5A, 8'd5);
    send_request(KIND_BYTE, 8'h5A);
    send_request(KIND_BYTE, 8'h3C);
    send_frame(8'h5A, 5, 1'b0, 1'b0, -1);
    send_frame(8'h07, 6, 1'b0, 1'b0, -1);
    send_frame(8'h08, 4, 1'b0, 1'b0, -1);
    drain();
  endtask

  task automatic test_output_backpressure();
    in_calm = 1'b1;
    stall_token++;
    repeat (4) send_frame(8'($urandom_range(255)), 24, 1'b0, 1'b0, -1);
    in_calm = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int calm_items);
    int stop_at;
    int calm_until;
    int pick;
    int lim;
    logic [BYTE_W-1:0] b;
    stop_at = n_requests + n_items;
    calm_until = n_requests + calm_items;
    while (n_requests < stop_at) begin
      in_calm  = (n_requests < calm_until);
      out_calm = in_calm;
      lim  = limit_now();
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_frame(8'($urandom_range(255)), pick_len(lim), 1'b0, 1'b0, -1);
      end else if (pick < 78) begin
        send_frame(8'($urandom_range(255)), pick_len(lim), 1'b0, 1'b1, -1);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 4)) send_request(KIND_BYTE, 8'($urandom_range(255)));
      end else if (pick < 91) begin
        send_frame(8'($urandom_range(255)), pick_len(lim), 1'b0, 1'b0,
                   $urandom_range(0, 8));
      end else if (pick < 96) begin
        send_request(KIND_BYTE, fs_reg);
        send_request(KIND_BYTE, ss_reg);
        send_request(KIND_BYTE, 8'($urandom_range(255)));
        send_request(KIND_BYTE, 8'($urandom_range(lim + 1, 255)));
      end else begin
        b = 8'($urandom_range(255));
        if (b == ss_reg) b = ~b;
        send_request(KIND_BYTE, fs_reg);
        send_request(KIND_BYTE, b);
      end
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_BYTE;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_FIRST_SYNC;
    cfg_wdata     <= '0;
    fs_reg      = FIRST_SYNC_RST;
    ss_reg      = SECOND_SYNC_RST;
    lim_reg     = LEN_LIMIT_RST;
    frame_phase = PH_SYNC1;
    sum_acc     = '0;
    held_id_m   = '0;
    held_len_m  = '0;
    byte_cnt_m  = '0;
    n_requests  = 0;
    n_frames    = 0;
    n_results   = 0;
    n_errors    = 0;
    idle_cycles = 0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    stall_token = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_register_settings();
    test_output_backpressure();
    program_regs(FIRST_SYNC_RST, SECOND_SYNC_RST, 8'(LEN_LIMIT_RST));
    test_random_traffic(50, 30);
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(1, 31)));
    test_random_traffic(40, 0);
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(33, 255)));
    test_random_traffic(40, 0);

    $display("Run: %0d link requests in %0d framing attempts, %0d results checked, %0d errors",
             n_requests, n_frames, n_results, n_errors);
    $display("Covered empty/full frames, bad sums, long lengths, timeouts, sync misses, stalls");
    if (n_errors == 0) begin
      $display("sum_checked_packet_deframer test passed");
    end else begin
      $display("sum_checked_packet_deframer test failed");
    end
    $finish;
  end

endmodule
